// ===== src/dedup_fifo_packet_buffer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the deduplicating packet buffer
// Shorthand for clocked assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DEDUP_FIFO_PACKET_BUFFER_MACROS_SVH
`define DEDUP_FIFO_PACKET_BUFFER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define DFPB_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dfpb assertion failed");

// When the trigger holds, the condition must hold in the next cycle.
`define DFPB_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("dfpb assertion failed");

`endif

// ===== src/dfpb_pkg.sv =====
// ----------------------------------------------------------------------------
// dfpb_pkg
// Types and constants shared by the deduplicating packet buffer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dfpb_pkg;

    localparam int ID_W      = 16;
    localparam int TIME_W    = 32;
    localparam int LIM_W     = 7;
    localparam int COUNT_W   = 7;
    localparam int KIND_W    = 2;
    localparam int ENTRY_W   = 2 * ID_W + TIME_W;
    localparam int IN_DATA_W = 128;
    localparam int OUT_DATA_W = 80;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 2'd0,
        KIND_FWD   = 2'd1,
        KIND_COUNT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   source;
        logic [ID_W-1:0]   destination;
        logic [TIME_W-1:0] timestamp;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
    } cmd_t;

    typedef struct packed {
        logic               added;
        logic               forward_valid;
        logic [ID_W-1:0]    out_source;
        logic [ID_W-1:0]    out_destination;
        logic [TIME_W-1:0]  out_timestamp;
        logic [COUNT_W-1:0] match_count;
    } res_t;

endpackage

`default_nettype wire

// ===== src/dfpb_ram.sv =====
// ----------------------------------------------------------------------------
// dfpb_ram
// Packet store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dfpb_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int WIDTH  = 64
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/dfpb_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfpb_ctrl
// Sequencer: keeps the ring pointers, scans stored packets through the
// memory read port and commits adds and forwards.
// ----------------------------------------------------------------------------
`default_nettype none

module dfpb_ctrl
    import dfpb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [LIM_W-1:0] mem_limit,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cmd_t             in_cmd,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output res_t                  res
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             pend_reg, pend_next;
    logic             dup_reg, dup_next;
    logic [CNT_W-1:0] hits_reg, hits_next;

    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [PTR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [ID_W-1:0]   rd_src;
    logic [ID_W-1:0]   rd_dst;
    logic [TIME_W-1:0] rd_ts;
    logic [CMP_W-1:0]  lim_eff;
    logic [CMP_W-1:0]  lim_raw;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] s;
        s = {1'b0, p} + (PTR_W + 1)'(1);
        if (s == (PTR_W + 1)'(DEPTH))
        begin
            return '0;
        end
        return s[PTR_W-1:0];
    endfunction

    dfpb_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (PTR_W),
        .WIDTH  (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_src = ram_rdata[ENTRY_W-1 -: ID_W];
    assign rd_dst = ram_rdata[TIME_W +: ID_W];
    assign rd_ts  = ram_rdata[TIME_W-1:0];

    always_comb
    begin
        lim_raw = CMP_W'(mem_limit);
        if (lim_raw == '0)
        begin
            lim_eff = CMP_W'(1);
        end
        else if (lim_raw > CMP_W'(DEPTH))
        begin
            lim_eff = CMP_W'(DEPTH);
        end
        else
        begin
            lim_eff = lim_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            scan_ptr_reg <= '0;
            scan_cnt_reg <= '0;
            pend_reg     <= 1'b0;
            dup_reg      <= 1'b0;
            hits_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            scan_ptr_reg <= scan_ptr_next;
            scan_cnt_reg <= scan_cnt_next;
            pend_reg     <= pend_next;
            dup_reg      <= dup_next;
            hits_reg     <= hits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        scan_ptr_next = scan_ptr_reg;
        scan_cnt_next = scan_cnt_reg;
        pend_next     = pend_reg;
        dup_next      = dup_reg;
        hits_next     = hits_reg;
        ram_we        = 1'b0;
        ram_waddr     = tail_reg;
        ram_wdata     = {cmd_reg.source, cmd_reg.destination, cmd_reg.timestamp};
        ram_re        = 1'b0;
        ram_raddr     = scan_ptr_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        res           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next      = in_cmd;
                    dup_next      = 1'b0;
                    hits_next     = '0;
                    scan_ptr_next = head_reg;
                    scan_cnt_next = '0;
                    pend_next     = 1'b0;
                    unique case (in_cmd.kind)
                        KIND_FWD:
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = head_reg;
                            state_next = ST_FINISH;
                        end
                        KIND_ADD, KIND_COUNT:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                pend_next = 1'b0;
                if (scan_cnt_reg != fill_reg)
                begin
                    ram_re        = 1'b1;
                    scan_ptr_next = ptr_inc(scan_ptr_reg);
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                end
                if (pend_reg)
                begin
                    if (rd_src == cmd_reg.source && rd_dst == cmd_reg.destination
                        && rd_ts == cmd_reg.timestamp)
                    begin
                        dup_next = 1'b1;
                    end
                    if (rd_dst == cmd_reg.destination && rd_ts >= cmd_reg.start_time
                        && rd_ts <= cmd_reg.end_time)
                    begin
                        hits_next = hits_reg + CNT_W'(1);
                    end
                end
                if (scan_cnt_reg == fill_reg && !pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                res_valid = 1'b1;
                unique case (cmd_reg.kind)
                    KIND_ADD:
                    begin
                        res.added = !dup_reg;
                        if (res_ready && !dup_reg)
                        begin
                            ram_we    = 1'b1;
                            tail_next = ptr_inc(tail_reg);
                            if (CMP_W'(fill_reg) >= lim_eff)
                            begin
                                head_next = ptr_inc(head_reg);
                            end
                            else
                            begin
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                    end
                    KIND_FWD:
                    begin
                        if (fill_reg != '0)
                        begin
                            res.forward_valid   = 1'b1;
                            res.out_source      = rd_src;
                            res.out_destination = rd_dst;
                            res.out_timestamp   = rd_ts;
                            if (res_ready)
                            begin
                                head_next = ptr_inc(head_reg);
                                fill_next = fill_reg - CNT_W'(1);
                            end
                        end
                    end
                    KIND_COUNT:
                    begin
                        res.match_count = COUNT_W'(hits_reg);
                    end
                    default:
                    begin
                        res = '0;
                    end
                endcase
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/dedup_fifo_packet_buffer.sv =====
// ----------------------------------------------------------------------------
// dedup_fifo_packet_buffer
// Bounded packet FIFO that refuses duplicate packets and counts packets by
// destination and timestamp range.
// ----------------------------------------------------------------------------
// One word is processed at a time. An add or a count scans every stored
// packet through the single read port of the packet memory, one packet per
// cycle, before it forms its result. A forward or an unknown kind skips the
// scan. A finished result sits in an output register, so the next word is
// accepted while the result still waits to be taken.
`default_nettype none

`include "dedup_fifo_packet_buffer_macros.svh"

module dedup_fifo_packet_buffer
    import dfpb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [LIM_W-1:0]      cfg_wr_data,    // memory_limit
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // source, destination, timestamp, start_time, end_time
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic [KIND_W-1:0]     s_axis_tuser,   // kind
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // added, forward_valid, out_source, out_destination, out_timestamp,
    // match_count, zero padding
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    logic [LIM_W-1:0] mem_limit_reg;
    logic             out_valid_reg, out_valid_next;
    res_t             out_res_reg, out_res_next;
    cmd_t             in_cmd;
    logic             res_valid;
    logic             res_ready;
    res_t             res;

    always_comb
    begin
        in_cmd.kind        = s_axis_tuser;
        in_cmd.source      = s_axis_tdata[15:0];
        in_cmd.destination = s_axis_tdata[31:16];
        in_cmd.timestamp   = s_axis_tdata[63:32];
        in_cmd.start_time  = s_axis_tdata[95:64];
        in_cmd.end_time    = s_axis_tdata[127:96];
    end

    dfpb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .mem_limit (mem_limit_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (in_cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            mem_limit_reg <= cfg_wr_data;
        end
    end

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0,
                            out_res_reg.match_count,
                            out_res_reg.out_timestamp,
                            out_res_reg.out_destination,
                            out_res_reg.out_source,
                            out_res_reg.forward_valid,
                            out_res_reg.added};

    `DFPB_ASSERT_ALWAYS(a_no_accept_while_result, !(s_axis_tready && res_valid))
    `DFPB_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `DFPB_ASSERT_NEXT(a_result_lands, res_valid && res_ready, m_axis_tvalid)

endmodule

`default_nettype wire

// ===== dv/dedup_fifo_packet_buffer_test.sv =====
// ----------------------------------------------------------------------------
// Deduplicating packet buffer testbench
// Drives add, forward, count and unknown words into the block through its
// input stream, checks every output word against the directed table or a
// predictor of the FIFO contents, runs the table first, then random phases
// under several memory limits, with random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dedup_fifo_packet_buffer_test
    import dfpb_pkg::*;
();

    localparam int BUF_DEPTH = 64;
    localparam int SCAN_CYCLES = BUF_DEPTH + 6;
    localparam int STALL_LIMIT = 2000;
    localparam int RECENT_MAX = 24;
    localparam int NUM_PHASES = 9;
    localparam int NUM_DIRECTED = 21;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam logic [ID_W-1:0] ID_ONES = '1;
    localparam logic [TIME_W-1:0] TIME_ONES = '1;

    localparam int PHASE_LIMIT [NUM_PHASES] = '{64, 3, 0, 127, 1, 64, 17, 2, 64};
    localparam int PHASE_ADD [NUM_PHASES] = '{80, 50, 50, 85, 50, 45, 55, 40, 50};
    localparam int PHASE_FWD [NUM_PHASES] = '{5, 20, 25, 5, 25, 35, 20, 40, 25};
    localparam int PHASE_WORDS [NUM_PHASES] = '{90, 60, 60, 90, 60, 70, 70, 60, 70};
    localparam int PHASE_GAPS [NUM_PHASES] = '{20, 30, 0, 15, 40, 10, 25, 20, 0};

    typedef struct packed {
        cmd_t word;
        logic known;
        res_t want;
    } row_t;

    localparam row_t DIRECTED_WORDS [NUM_DIRECTED] = '{
        '{'{KIND_FWD, ID_ONES, ID_ONES, TIME_ONES, TIME_ONES, TIME_ONES}, 1'b1,
          '{1'b0, 1'b0, 16'h0, 16'h0, 32'h0, 7'd0}},
        '{'{KIND_COUNT, ID_ONES, 16'h0, TIME_ONES, 32'h0, TIME_ONES}, 1'b1,
          '{1'b0, 1'b0, 16'h0, 16'h0, 32'h0, 7'd0}},
        '{'{KIND_ADD, 16'h0, 16'h0, 32'h0, TIME_ONES, TIME_ONES}, 1'b1,
          '{1'b1, 1'b0, 16'h0, 16'h0, 32'h0, 7'd0}},
        '{'{KIND_ADD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
          '{1'b0, 1'b0, 16'h0, 16'h0, 32'h0, 7'd0}},
        '{'{KIND_ADD, ID_ONES, ID_ONES, TIME_ONES, 32'h0, 32'h0}, 1'b1,
          '{1'b1, 1'b0, 16'h0, 16'h0, 32'h0, 7'd0}},
        '{'{KIND_ADD, ID_ONES, ID_ONES, 32'hFFFF_FFFE, 32'h0, 32'h0}, 1'b1,
          '{1'b1, 1'b0, 16'h0, 16'h0, 32'h0, 7'd0}},
        '{'{KIND_ADD, ID_ONES, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
          '{1'b1, 1'b0, 16'h0, 16'h0, 32'h0, 7'd0}},
        '{'{KIND_COUNT, 16'h0, ID_ONES, 32'h0, 32'h0, TIME_ONES}, 1'b1,
          '{1'b0, 1'b0, 16'h0, 16'h0, 32'h0, 7'd2}},
        '{'{KIND_COUNT, 16'h0, ID_ONES, 32'h0, TIME_ONES, 32'hFFFF_FFFE}, 1'b1,
          '{1'b0, 1'b0, 16'h0, 16'h0, 32'h0, 7'd0}},
        '{'{KIND_COUNT, 16'h0, ID_ONES, 32'h0, TIME_ONES, TIME_ONES}, 1'b1,
          '{1'b0, 1'b0, 16'h0, 16'h0, 32'h0, 7'd1}},
        '{'{KIND_COUNT, ID_ONES, 16'h0, TIME_ONES, 32'h0, 32'h0}, 1'b1,
          '{1'b0, 1'b0, 16'h0, 16'h0, 32'h0, 7'd2}},
        '{'{KIND_NONE, ID_ONES, ID_ONES, TIME_ONES, TIME_ONES, TIME_ONES}, 1'b1,
          '{1'b0, 1'b0, 16'h0, 16'h0, 32'h0, 7'd0}},
        '{'{KIND_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
          '{1'b0, 1'b1, 16'h0, 16'h0, 32'h0, 7'd0}},
        '{'{KIND_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
          '{1'b0, 1'b1, ID_ONES, ID_ONES, TIME_ONES, 7'd0}},
        '{'{KIND_ADD, 16'h1234, 16'hABCD, 32'h5555_AAAA, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_ADD, 16'h1234, 16'hABCD, 32'h5555_AAAA, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_COUNT, 16'h0, 16'hABCD, 32'h0, 32'h5555_AAAA, 32'h5555_AAAA}, 1'b0, '0},
        '{'{KIND_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
        '{'{KIND_FWD, ID_ONES, ID_ONES, TIME_ONES, TIME_ONES, TIME_ONES}, 1'b1,
          '{1'b0, 1'b0, 16'h0, 16'h0, 32'h0, 7'd0}}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [LIM_W-1:0] cfg_wr_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // source, destination, timestamp, start_time, end_time
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [KIND_W-1:0] s_axis_tuser = '0;   // kind
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // added, forward_valid, out_source, out_destination, out_timestamp,
    // match_count, zero padding
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [ID_W-1:0] held_source [BUF_DEPTH];
    logic [ID_W-1:0] held_destination [BUF_DEPTH];
    logic [TIME_W-1:0] held_timestamp [BUF_DEPTH];
    int oldest_slot = 0;
    int free_slot = 0;
    int held_count = 0;
    logic [LIM_W-1:0] packet_limit = LIMIT_RESET;

    res_t awaited_results [$];
    cmd_t recent_packets [$];
    int fail_count = 0;
    int gap_pct = 0;
    int quiet_cycles = 0;

    dedup_fifo_packet_buffer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic predict_packet_op(input cmd_t c, output res_t r);
        int slot;
        int cap;
        int hits;
        logic seen;
        r = '0;
        case (c.kind)
            KIND_ADD:
            begin
                seen = 1'b0;
                for (int i = 0; i < held_count; i++)
                begin
                    slot = (oldest_slot + i) % BUF_DEPTH;
                    if (held_source[slot] == c.source && held_destination[slot] == c.destination
                        && held_timestamp[slot] == c.timestamp)
                        seen = 1'b1;
                end
                if (!seen)
                begin
                    cap = (packet_limit == 0) ? 1 :
                          (packet_limit > BUF_DEPTH) ? BUF_DEPTH : int'(packet_limit);
                    if (held_count >= cap)
                    begin
                        oldest_slot = (oldest_slot + 1) % BUF_DEPTH;
                        held_count--;
                    end
                    held_source[free_slot] = c.source;
                    held_destination[free_slot] = c.destination;
                    held_timestamp[free_slot] = c.timestamp;
                    free_slot = (free_slot + 1) % BUF_DEPTH;
                    held_count++;
                    r.added = 1'b1;
                end
            end
            KIND_FWD:
            begin
                if (held_count > 0)
                begin
                    r.forward_valid = 1'b1;
                    r.out_source = held_source[oldest_slot];
                    r.out_destination = held_destination[oldest_slot];
                    r.out_timestamp = held_timestamp[oldest_slot];
                    oldest_slot = (oldest_slot + 1) % BUF_DEPTH;
                    held_count--;
                end
            end
            KIND_COUNT:
            begin
                hits = 0;
                for (int i = 0; i < held_count; i++)
                begin
                    slot = (oldest_slot + i) % BUF_DEPTH;
                    if (held_destination[slot] == c.destination
                        && held_timestamp[slot] >= c.start_time
                        && held_timestamp[slot] <= c.end_time)
                        hits++;
                end
                r.match_count = hits[COUNT_W-1:0];
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic cmd_t random_packet_op(input int add_pct, input int fwd_pct);
        cmd_t c;
        cmd_t pick;
        int roll;
        c.kind = KIND_COUNT;
        c.source = ID_W'($urandom_range(32'hFFFF));
        c.destination = ID_W'($urandom_range(32'hFFFF));
        c.timestamp = $urandom;
        c.start_time = $urandom;
        c.end_time = $urandom;
        pick = (recent_packets.size() > 0)
            ? recent_packets[$urandom_range(recent_packets.size() - 1)] : c;
        roll = $urandom_range(99);
        if (roll < add_pct)
        begin
            c.kind = KIND_ADD;
            roll = $urandom_range(9);
            if (roll < 3)
            begin
                c.source = pick.source;
                c.destination = pick.destination;
                c.timestamp = pick.timestamp;
            end
            else if (roll < 8)
            begin
                c.source = ID_W'($urandom_range(3));
                c.destination = ID_W'($urandom_range(3));
                c.timestamp = TIME_W'($urandom_range(15));
            end
            recent_packets.push_back(c);
            if (recent_packets.size() > RECENT_MAX)
                void'(recent_packets.pop_front());
        end
        else if (roll < add_pct + fwd_pct)
            c.kind = KIND_FWD;
        else if (roll >= 97)
            c.kind = KIND_NONE;
        else
        begin
            roll = $urandom_range(3);
            if (roll < 2)
                c.destination = ID_W'($urandom_range(3));
            else if (roll == 2)
                c.destination = pick.destination;
            case ($urandom_range(4))
                0:
                begin
                    c.start_time = TIME_W'($urandom_range(15));
                    c.end_time = TIME_W'($urandom_range(15));
                end
                1:
                begin
                    c.start_time = '0;
                    c.end_time = TIME_ONES;
                end
                2:
                begin
                    c.start_time = pick.timestamp;
                    c.end_time = pick.timestamp;
                end
                3:
                begin
                    c.start_time = pick.timestamp - 1;
                    c.end_time = pick.timestamp + 1;
                end
                default:
                begin
                end
            endcase
        end
        return c;
    endfunction

    // Entered and left right after a rising edge.
    task automatic send_packet_op(input cmd_t c, input logic known, input res_t want);
        res_t predicted;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {c.end_time, c.start_time, c.timestamp, c.destination, c.source};
        s_axis_tuser <= c.kind;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        predict_packet_op(c, predicted);
        awaited_results.push_back(known ? want : predicted);
        @(posedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SCAN_CYCLES) @(posedge clk);
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(negedge clk)
    begin : result_check
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t ns: unexpected result word, expected none, actual %h",
                         $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                compare_field("added", 32'(want.added), 32'(m_axis_tdata[0]));
                compare_field("forward_valid", 32'(want.forward_valid), 32'(m_axis_tdata[1]));
                compare_field("out_source", 32'(want.out_source), 32'(m_axis_tdata[17:2]));
                compare_field("out_destination", 32'(want.out_destination),
                              32'(m_axis_tdata[33:18]));
                compare_field("out_timestamp", want.out_timestamp, m_axis_tdata[65:34]);
                compare_field("match_count", 32'(want.match_count), 32'(m_axis_tdata[72:66]));
                compare_field("padding", 32'h0, 32'(m_axis_tdata[79:73]));
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (gap_pct > 0 && $urandom_range(99) < gap_pct / 2)
            begin
                stall_left = $urandom_range(5);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : packet_source
        cmd_t c;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gap_pct = 20;
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_packet_op(DIRECTED_WORDS[i].word, DIRECTED_WORDS[i].known,
                           DIRECTED_WORDS[i].want);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= LIM_W'(PHASE_LIMIT[p]);
            packet_limit = LIM_W'(PHASE_LIMIT[p]);
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            gap_pct = PHASE_GAPS[p];
            for (int n = 0; n < PHASE_WORDS[p]; n++)
            begin
                c = random_packet_op(PHASE_ADD[p], PHASE_FWD[p]);
                send_packet_op(c, 1'b0, '0);
            end
        end
        drain_results();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
